// ----- src/slru_pkg.sv -----
// Shared types and constants for the segmented LRU replacement policy core.
// No dependencies; imported by segmented_lru_policy_core and its testbench.
package slru_pkg;

    // Store geometry
    localparam int MAX_SEGMENTS  = 4;
    localparam int SEGMENT_DEPTH = 16;
    localparam int KEY_BITS      = 32;

    // Derived widths
    localparam int SEG_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int SEGN_W = $clog2(MAX_SEGMENTS + 1);
    localparam int POS_W  = (SEGMENT_DEPTH > 1) ? $clog2(SEGMENT_DEPTH) : 1;
    localparam int OCC_W  = $clog2(SEGMENT_DEPTH + 1);

    // Fixed port widths
    localparam int COUNT_W    = 3;
    localparam int CAP_W      = 5;
    localparam int CFG_DATA_W = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int PORT_KEY_W = 32;
    localparam int HIT_SEG_W  = 2;

    // Register reset values
    localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd4;
    localparam logic [CAP_W-1:0]   CAP_RESET   = 5'd16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_COUNT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_CAPACITY = 1'b1;

    typedef logic [KEY_BITS-1:0] key_t;
    typedef logic [OCC_W-1:0]    occ_t;
    typedef logic [POS_W-1:0]    pos_t;
    typedef logic [SEG_W-1:0]    seg_t;
    typedef logic [SEGN_W-1:0]   segn_t;

endpackage

// ----- src/segmented_lru_policy_core.sv -----
// Segmented LRU replacement policy core: lookup, promotion, demotion, eviction.
// Depends on slru_pkg for geometry, widths and register indexes.
//
// One request is accepted at every clock edge where start is high; busy is
// always low, so a new request may follow in every cycle. Each request gives
// exactly one result, strobed by done for one cycle: the key is registered,
// then the 64-way parallel key compare and the segment shift update load the
// result register together with the store. Results cannot be held off by the
// receiver.
// Reset empties every segment at once; no clearing pass is needed.
module segmented_lru_policy_core
    import slru_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [PORT_KEY_W-1:0] object_key,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  done,
    output logic                  hit,
    output logic [HIT_SEG_W-1:0]  hit_segment,
    output logic                  evict_valid,
    output logic [PORT_KEY_W-1:0] evicted_key
);

    // Configuration
    logic [COUNT_W-1:0] seg_count_reg;
    logic [CAP_W-1:0]   seg_cap_reg;
    segn_t              nseg_use;
    occ_t               cap_use;

    // Request register
    logic req_valid_reg;
    key_t key_reg;

    // Segment store: position 0 is most recent
    key_t key_store_reg  [MAX_SEGMENTS][SEGMENT_DEPTH];
    key_t key_store_next [MAX_SEGMENTS][SEGMENT_DEPTH];
    occ_t occ_reg        [MAX_SEGMENTS];
    occ_t occ_next       [MAX_SEGMENTS];

    // Lookup and update
    logic seg_hit  [MAX_SEGMENTS];
    pos_t seg_pos  [MAX_SEGMENTS];
    logic seg_over [MAX_SEGMENTS];
    key_t seg_tail [MAX_SEGMENTS];
    logic found;
    seg_t fs;
    logic has_up;
    logic evict_flag;
    key_t evict_key;

    // Result registers
    logic                 done_reg;
    logic                 hit_reg;
    logic [HIT_SEG_W-1:0] hit_segment_reg;
    logic                 evict_valid_reg;
    key_t                 evicted_key_reg;

    assign busy = 1'b0;

    // Clamp configuration to the supported range
    always_comb
    begin
        if (seg_count_reg == '0)
            nseg_use = SEGN_W'(1);
        else if (32'(seg_count_reg) > MAX_SEGMENTS)
            nseg_use = SEGN_W'(MAX_SEGMENTS);
        else
            nseg_use = SEGN_W'(seg_count_reg);

        if (seg_cap_reg == '0)
            cap_use = OCC_W'(1);
        else if (32'(seg_cap_reg) > SEGMENT_DEPTH)
            cap_use = OCC_W'(SEGMENT_DEPTH);
        else
            cap_use = OCC_W'(seg_cap_reg);
    end

    // Lookup, then per-segment insert / remove
    always_comb
    begin
        pos_t fp;
        logic demote_over;
        key_t demoted;
        logic do_ins;
        logic do_rem;
        pos_t op_pos;
        key_t ins_val;

        key_store_next = key_store_reg;
        occ_next       = occ_reg;

        // Parallel match, most recent position wins within a segment
        for (int s = 0; s < MAX_SEGMENTS; s++)
        begin
            seg_hit[s] = 1'b0;
            seg_pos[s] = '0;
            for (int p = SEGMENT_DEPTH - 1; p >= 0; p--)
            begin
                if ((s < int'(nseg_use)) && (p < int'(occ_reg[s])) &&
                    (key_store_reg[s][p] == key_reg))
                begin
                    seg_hit[s] = 1'b1;
                    seg_pos[s] = POS_W'(p);
                end
            end
            seg_over[s] = (occ_reg[s] >= cap_use);
            seg_tail[s] = key_store_reg[s][POS_W'(occ_reg[s] - 1'b1)];
        end

        // Lowest segment wins
        found = 1'b0;
        fs    = '0;
        for (int s = MAX_SEGMENTS - 1; s >= 0; s--)
        begin
            if (seg_hit[s])
            begin
                found = 1'b1;
                fs    = SEG_W'(s);
            end
        end
        fp     = seg_pos[fs];
        has_up = found && ((int'(fs) + 1) < int'(nseg_use));

        // Key pushed out of the segment above the hit
        demote_over = 1'b0;
        demoted     = '0;
        for (int s = 0; s < MAX_SEGMENTS; s++)
        begin
            if (has_up && (s == int'(fs) + 1))
            begin
                demote_over = seg_over[s];
                demoted     = seg_tail[s];
            end
        end

        // Per segment: insert at front shifting up to op_pos, or remove at op_pos
        for (int s = 0; s < MAX_SEGMENTS; s++)
        begin
            do_ins  = 1'b0;
            do_rem  = 1'b0;
            op_pos  = POS_W'(SEGMENT_DEPTH - 1);
            ins_val = key_reg;
            if (req_valid_reg)
            begin
                if ((!found && (s == 0)) || (has_up && (s == int'(fs) + 1)))
                begin
                    // plain push to the front; overflow drops the tail
                    do_ins      = 1'b1;
                    occ_next[s] = seg_over[s] ? occ_reg[s] : occ_reg[s] + 1'b1;
                end
                else if (found && (s == int'(fs)))
                begin
                    op_pos = fp;
                    if (has_up && !demote_over)
                    begin
                        do_rem      = 1'b1;
                        occ_next[s] = occ_reg[s] - 1'b1;
                    end
                    else
                    begin
                        // remove plus push of the demoted key, or top refresh
                        do_ins      = 1'b1;
                        ins_val     = has_up ? demoted : key_reg;
                        occ_next[s] = ((occ_reg[s] - 1'b1) >= cap_use) ?
                                      occ_reg[s] - 1'b1 : occ_reg[s];
                    end
                end
            end

            for (int q = 0; q < SEGMENT_DEPTH; q++)
            begin
                if (do_ins)
                begin
                    if (q == 0)
                        key_store_next[s][q] = ins_val;
                    else if (q <= int'(op_pos))
                        key_store_next[s][q] = key_store_reg[s][q-1];
                end
                else if (do_rem)
                begin
                    if ((q >= int'(op_pos)) && (q + 1 < SEGMENT_DEPTH))
                        key_store_next[s][q] = key_store_reg[s][q+1];
                end
            end
        end

        evict_flag = !found && seg_over[0];
        evict_key  = evict_flag ? seg_tail[0] : '0;
    end

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_count_reg <= COUNT_RESET;
            seg_cap_reg   <= CAP_RESET;
            req_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
            for (int s = 0; s < MAX_SEGMENTS; s++)
                occ_reg[s] <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SEGMENT_COUNT:    seg_count_reg <= cfg_data[COUNT_W-1:0];
                    CFG_SEGMENT_CAPACITY: seg_cap_reg   <= cfg_data[CAP_W-1:0];
                    default:              ;
                endcase
            end
            req_valid_reg <= start && !busy;
            done_reg      <= req_valid_reg;
            occ_reg       <= occ_next;
        end
    end

    // Payload: request key, store contents, result fields
    always_ff @(posedge clk)
    begin
        if (start && !busy)
            key_reg <= KEY_BITS'(object_key);
        key_store_reg <= key_store_next;
        if (req_valid_reg)
        begin
            hit_reg         <= found;
            hit_segment_reg <= found ? HIT_SEG_W'(fs) : '0;
            evict_valid_reg <= evict_flag;
            evicted_key_reg <= evict_key;
        end
    end

    assign done        = done_reg;
    assign hit         = hit_reg;
    assign hit_segment = hit_segment_reg;
    assign evict_valid = evict_valid_reg;
    assign evicted_key = PORT_KEY_W'(evicted_key_reg);

`ifndef SYNTHESIS
    // every registered request yields a result beat on the next cycle
    a_req_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid_reg |=> done)
        else $error("request did not produce a result beat");

    // an eviction leaves segment 0 occupancy unchanged
    a_evict_keeps_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (done && evict_valid) |-> (occ_reg[0] == $past(occ_reg[0])))
        else $error("segment 0 occupancy changed on eviction");

    // an eviction only happens when segment 0 was full
    a_evict_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && evict_valid) |-> ($past(occ_reg[0]) >= $past(cap_use)))
        else $error("eviction from a segment below capacity");
`endif

endmodule

// ----- verif/segmented_lru_policy_core_test.sv -----
// Self-checking testbench for segmented_lru_policy_core: directed and random requests
// are run against a shadow segmented LRU store. Depends on slru_pkg and the core RTL.
module segmented_lru_policy_core_test
    import slru_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD  = 10;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_LIMIT = 200;
    localparam int PIPE_CYCLES = 4;

    typedef struct packed {
        logic                  hit;
        logic [HIT_SEG_W-1:0]  hit_segment;
        logic                  evict_valid;
        logic [PORT_KEY_W-1:0] evicted_key;
    } access_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [PORT_KEY_W-1:0] object_key;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  done;
    logic                  hit;
    logic [HIT_SEG_W-1:0]  hit_segment;
    logic                  evict_valid;
    logic [PORT_KEY_W-1:0] evicted_key;

    // Shadow of the policy state
    key_t               segment_keys [MAX_SEGMENTS][SEGMENT_DEPTH];
    int                 segment_fill [MAX_SEGMENTS];
    logic [COUNT_W-1:0] count_shadow;
    logic [CAP_W-1:0]   capacity_shadow;

    access_result_t pending_accesses[$];
    int             failures;
    int             cycle_count;
    bit             no_idle;
    key_t           key_pool[$];

    segmented_lru_policy_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .object_key  (object_key),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .hit         (hit),
        .hit_segment (hit_segment),
        .evict_valid (evict_valid),
        .evicted_key (evicted_key)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Run limit
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    function automatic int segments_in_use();
        if (count_shadow == 0) return 1;
        if (count_shadow > MAX_SEGMENTS) return MAX_SEGMENTS;
        return int'(count_shadow);
    endfunction

    function automatic int capacity_in_use();
        if (capacity_shadow == 0) return 1;
        if (capacity_shadow > SEGMENT_DEPTH) return SEGMENT_DEPTH;
        return int'(capacity_shadow);
    endfunction

    // Insert as most recent; an overfull segment pushes out its least recent key
    function automatic void insert_most_recent(input int seg, input key_t key,
                                               output bit over, output key_t pushed);
        int n;
        n = segment_fill[seg];
        over = (n >= capacity_in_use());
        pushed = '0;
        if (over)
        begin
            pushed = segment_keys[seg][n-1];
            for (int q = n - 1; q > 0; q--) segment_keys[seg][q] = segment_keys[seg][q-1];
        end
        else
        begin
            for (int q = n; q > 0; q--) segment_keys[seg][q] = segment_keys[seg][q-1];
            segment_fill[seg] = n + 1;
        end
        segment_keys[seg][0] = key;
    endfunction

    // Lookup plus promotion, demotion or eviction for one request
    function automatic access_result_t slru_access(input key_t key);
        access_result_t res;
        int             nseg;
        int             fs;
        int             fp;
        bit             found;
        bit             over;
        key_t           moved;
        key_t           spare;
        nseg  = segments_in_use();
        found = 1'b0;
        fs    = 0;
        fp    = 0;
        res   = '0;
        for (int s = 0; s < nseg && !found; s++)
        begin
            for (int p = 0; p < segment_fill[s] && !found; p++)
            begin
                if (segment_keys[s][p] == key)
                begin
                    found = 1'b1;
                    fs = s;
                    fp = p;
                end
            end
        end
        if (found)
        begin
            for (int q = fp; q + 1 < segment_fill[fs]; q++)
                segment_keys[fs][q] = segment_keys[fs][q+1];
            segment_fill[fs]--;
            if (fs + 1 < nseg)
            begin
                insert_most_recent(fs + 1, key, over, moved);
                if (over) insert_most_recent(fs, moved, over, spare);
            end
            else
                insert_most_recent(fs, key, over, spare);
            res.hit         = 1'b1;
            res.hit_segment = fs[HIT_SEG_W-1:0];
        end
        else
        begin
            insert_most_recent(0, key, over, moved);
            res.evict_valid = over;
            res.evicted_key = over ? moved : '0;
        end
        return res;
    endfunction

    // Result checker: one beat per done strobe
    always @(posedge clk)
    begin
        access_result_t want;
        if (rst_n && done)
        begin
            if (pending_accesses.size() == 0)
            begin
                $error("result beat with nothing outstanding");
                failures++;
            end
            else
            begin
                want = pending_accesses.pop_front();
                if (hit !== want.hit)
                begin
                    $error("hit expected %0h got %0h", want.hit, hit);
                    failures++;
                end
                if (hit_segment !== want.hit_segment)
                begin
                    $error("hit_segment expected %0h got %0h", want.hit_segment, hit_segment);
                    failures++;
                end
                if (evict_valid !== want.evict_valid)
                begin
                    $error("evict_valid expected %0h got %0h", want.evict_valid, evict_valid);
                    failures++;
                end
                if (evicted_key !== want.evicted_key)
                begin
                    $error("evicted_key expected %0h got %0h", want.evicted_key, evicted_key);
                    failures++;
                end
            end
        end
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 19);
    endfunction

    // Send one request beat, then idle for a drawn number of cycles
    task automatic send_request(input key_t key);
        int gap;
        @(negedge clk);
        start      = 1'b1;
        object_key = key;
        do @(posedge clk); while (busy);
        pending_accesses.push_back(slru_access(key));
        gap = draw_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            start      = 1'b0;
            object_key = $urandom();
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Stop requests and let every outstanding result come back
    task automatic settle_pipeline();
        @(negedge clk);
        start = 1'b0;
        while (pending_accesses.size() != 0) @(posedge clk);
        repeat (PIPE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        settle_pipeline();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge clk);
        if (idx == CFG_SEGMENT_COUNT) count_shadow = value[COUNT_W-1:0];
        else capacity_shadow = value[CAP_W-1:0];
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_geometry(input int segs, input int cap);
        write_register(CFG_SEGMENT_COUNT, CFG_DATA_W'(segs));
        write_register(CFG_SEGMENT_CAPACITY, CFG_DATA_W'(cap));
    endtask

    // Key extremes and promotion through every segment up to a top refresh
    task automatic test_promotion_ladder();
        send_request(32'h0000_0000);
        send_request(32'hFFFF_FFFF);
        repeat (4) send_request(32'h0000_0000);
        send_request(32'hFFFF_FFFF);
    endtask

    // Eviction from segment 0, demotion on overflow, hidden duplicate after shrink
    task automatic test_eviction_and_demotion();
        set_geometry(2, 1);
        send_request(32'hAAAA_AAAA);
        send_request(32'h5555_5555);
        send_request(32'h5555_5555);
        send_request(32'h1234_5678);
        send_request(32'h1234_5678);
        send_request(32'h5555_5555);
        write_register(CFG_SEGMENT_COUNT, CFG_DATA_W'(1));
        send_request(32'h5555_5555);
        send_request(32'h5555_5555);
        write_register(CFG_SEGMENT_COUNT, CFG_DATA_W'(2));
        send_request(32'h5555_5555);
    endtask

    // Zero and above-range register values are clamped
    task automatic test_register_clamping();
        set_geometry(0, 0);
        send_request(32'h8000_0001);
        send_request(32'h7FFF_FFFE);
        set_geometry(7, 31);
        send_request(32'h7FFF_FFFE);
        send_request(32'h8000_0001);
    endtask

    // Capacity lowered under occupancy: one key out per insertion
    task automatic test_capacity_shrink();
        set_geometry(4, 16);
        for (int i = 0; i < 5; i++) send_request($urandom());
        write_register(CFG_SEGMENT_CAPACITY, CFG_DATA_W'(2));
        for (int i = 0; i < 3; i++) send_request($urandom());
    endtask

    // Mostly keys from a small pool sized to the cache, some fresh keys
    task automatic run_random_phase(input int segs, input int cap, input int items);
        int pool_size;
        set_geometry(segs, cap);
        no_idle   = ($urandom_range(0, 3) == 0);
        pool_size = $urandom_range(1, 2 * segments_in_use() * capacity_in_use() + 8);
        key_pool.delete();
        for (int i = 0; i < pool_size; i++) key_pool.push_back($urandom());
        for (int i = 0; i < items; i++)
        begin
            if ($urandom_range(0, 9) == 0) send_request($urandom());
            else send_request(key_pool[$urandom_range(0, pool_size - 1)]);
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(1, 1, 145);
        run_random_phase(4, 16, 145);
        run_random_phase(2, 5, 145);
        run_random_phase(3, 8, 145);
        run_random_phase(4, 2, 145);
        run_random_phase(0, 0, 145);
        run_random_phase(7, 31, 145);
        run_random_phase(1, 16, 145);
        run_random_phase($urandom_range(0, 7), $urandom_range(0, 31), 145);
        run_random_phase($urandom_range(0, 7), $urandom_range(0, 31), 145);
    endtask

    // Test sequence
    initial
    begin
        int drain;
        failures        = 0;
        no_idle         = 1'b0;
        rst_n           = 1'b0;
        start           = 1'b0;
        object_key      = '0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_SEGMENT_COUNT;
        cfg_data        = '0;
        count_shadow    = COUNT_RESET;
        capacity_shadow = CAP_RESET;
        for (int s = 0; s < MAX_SEGMENTS; s++) segment_fill[s] = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_promotion_ladder();
        test_eviction_and_demotion();
        test_register_clamping();
        test_capacity_shrink();
        test_random_traffic();

        // Drain, bounded
        @(negedge clk);
        start = 1'b0;
        drain = 0;
        while (pending_accesses.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (PIPE_CYCLES) @(posedge clk);
        if (pending_accesses.size() != 0)
        begin
            $error("%0d results never arrived", pending_accesses.size());
            failures++;
        end
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
src/slru_pkg.sv
src/segmented_lru_policy_core.sv
verif/segmented_lru_policy_core_test.sv
